[rtl/clkf_pkg.sv]
package clkf_pkg;

  localparam int FREQ_W    = 26;
  localparam int N_W       = 9;
  localparam int M_W       = 6;
  localparam int PROD_W    = FREQ_W + N_W;
  localparam int DIVR_W    = 9;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [FREQ_W-1:0] HSI_RESET = 26'd16000000;
  localparam logic [FREQ_W-1:0] HSE_RESET = 26'd8000000;

  localparam logic [CFG_IDX_W-1:0] REG_HSI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HSE = 2'd1;

  typedef enum logic [1:0] {
    SRC_HSI  = 2'd0,
    SRC_HSE  = 2'd1,
    SRC_PLL  = 2'd2,
    SRC_NONE = 2'd3
  } src_t;

  typedef struct packed {
    logic [3:0] ahb;
    logic [2:0] apb1;
    logic [2:0] apb2;
    logic       err;
  } ctrl_t;

  typedef struct packed {
    logic [OUT_W-1:0] core;
    logic [OUT_W-1:0] apb1;
    logic [OUT_W-1:0] apb2;
    logic [OUT_W-1:0] tim1;
    logic [OUT_W-1:0] tim2;
    logic             err;
  } res_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    sh = 4'({1'b0, code[2:0]}) + 4'd1;
    if (code[2]) begin
      sh = sh + 4'd1;
    end
    if (!code[3]) begin
      sh = 4'd0;
    end
    return sh;
  endfunction

  function automatic logic [PROD_W-1:0] apb_shift(input logic [PROD_W-1:0] core,
                                                  input logic [2:0] code,
                                                  input logic timer);
    logic [2:0] sh;
    sh = timer ? (code - 3'd2) : (code - 3'd3);
    if (!code[2]) begin
      sh = 3'd0;
    end
    return core >> sh;
  endfunction

  function automatic logic [OUT_W-1:0] sat32(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

endpackage

[rtl/clkf_if.sv]
interface clkf_in_if import clkf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       clock_source;
  logic [3:0]       ahb_prescale;
  logic [2:0]       apb1_prescale;
  logic [2:0]       apb2_prescale;
  logic             pll_from_hse;
  logic [N_W-1:0]   pll_mul_n;
  logic [M_W-1:0]   pll_div_m;
  logic [1:0]       pll_div_p_code;

  modport source(output valid, clock_source, ahb_prescale, apb1_prescale, apb2_prescale,
                 pll_from_hse, pll_mul_n, pll_div_m, pll_div_p_code,
                 input ready);
  modport sink(input valid, clock_source, ahb_prescale, apb1_prescale, apb2_prescale,
               pll_from_hse, pll_mul_n, pll_div_m, pll_div_p_code,
               output ready);
endinterface

interface clkf_out_if import clkf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] core_hz;
  logic [OUT_W-1:0] apb1_hz;
  logic [OUT_W-1:0] apb2_hz;
  logic [OUT_W-1:0] apb1_timer_hz;
  logic [OUT_W-1:0] apb2_timer_hz;
  logic             div_error;

  modport source(output valid, core_hz, apb1_hz, apb2_hz, apb1_timer_hz, apb2_timer_hz,
                 div_error, input ready);
  modport sink(input valid, core_hz, apb1_hz, apb2_hz, apb1_timer_hz, apb2_timer_hz,
               div_error, output ready);
endinterface

interface clkf_cfg_if import clkf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FREQ_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/clkf_front.sv]
module clkf_front import clkf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  clkf_cfg_if.sink          cfg,
  clkf_in_if.sink           query,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_prod,
  output logic [DIVR_W-1:0] out_divisor,
  output ctrl_t             out_ctrl
);

  logic [FREQ_W-1:0] hsi;
  logic [FREQ_W-1:0] hse;

  logic [FREQ_W-1:0] freq_next;
  logic [N_W-1:0]    mul_next;
  logic [DIVR_W-1:0] divisor_next;
  logic              err_next;
  logic [DIVR_W-1:0] m_ext;

  logic              v1;
  logic [FREQ_W-1:0] freq1;
  logic [N_W-1:0]    mul1;
  logic [DIVR_W-1:0] divisor1;
  ctrl_t             ctrl1;
  logic [PROD_W-1:0] prod_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsi <= HSI_RESET;
      hse <= HSE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HSI: hsi <= cfg.data;
        REG_HSE: hse <= cfg.data;
        default: ;
      endcase
    end
  end

  assign query.ready = adv;
  assign m_ext       = DIVR_W'(query.pll_div_m);

  always_comb begin
    freq_next    = '0;
    mul_next     = '0;
    divisor_next = DIVR_W'(1);
    err_next     = 1'b0;
    case (src_t'(query.clock_source))
      SRC_HSI: begin
        freq_next = hsi;
        mul_next  = N_W'(1);
      end
      SRC_HSE: begin
        freq_next = hse;
        mul_next  = N_W'(1);
      end
      SRC_PLL: begin
        freq_next = query.pll_from_hse ? hse : hsi;
        if (query.pll_div_m == '0) begin
          err_next = 1'b1;
        end else begin
          mul_next = query.pll_mul_n;
          case (query.pll_div_p_code)
            2'd0:    divisor_next = m_ext << 1;
            2'd1:    divisor_next = m_ext << 2;
            2'd2:    divisor_next = (m_ext << 2) + (m_ext << 1);
            default: divisor_next = m_ext << 3;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign prod_c = PROD_W'(freq1) * PROD_W'(mul1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= query.valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      freq1       <= freq_next;
      mul1        <= mul_next;
      divisor1    <= divisor_next;
      ctrl1       <= '{ahb: query.ahb_prescale, apb1: query.apb1_prescale,
                       apb2: query.apb2_prescale, err: err_next};
      out_prod    <= prod_c;
      out_divisor <= divisor1;
      out_ctrl    <= ctrl1;
    end
  end

endmodule

[rtl/clkf_div.sv]
module clkf_div import clkf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [PROD_W-1:0] in_prod,
  input  logic [DIVR_W-1:0] in_divisor,
  input  ctrl_t             in_ctrl,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_quot,
  output ctrl_t             out_ctrl
);

  localparam int STAGES = PROD_W;

  logic              v    [STAGES];
  logic [PROD_W-1:0] dq   [STAGES];
  ctrl_t             ctrl [STAGES];
  logic [DIVR_W-1:0] rem  [STAGES-1];
  logic [DIVR_W-1:0] dv   [STAGES-1];

  logic [PROD_W-1:0] dq_c  [STAGES];
  logic [DIVR_W-1:0] rem_c [STAGES-1];

  logic [DIVR_W-1:0] prem;
  logic [DIVR_W-1:0] pdv;
  logic [PROD_W-1:0] pdq;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W-1:0] nrem;
  logic              qbit;

  always_comb begin
    prem  = '0;
    pdv   = '0;
    pdq   = '0;
    trial = '0;
    nrem  = '0;
    qbit  = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        prem = '0;
        pdv  = in_divisor;
        pdq  = in_prod;
      end else begin
        prem = rem[i-1];
        pdv  = dv[i-1];
        pdq  = dq[i-1];
      end
      trial = {prem, pdq[PROD_W-1]};
      if (trial >= {1'b0, pdv}) begin
        nrem = DIVR_W'(trial - {1'b0, pdv});
        qbit = 1'b1;
      end else begin
        nrem = trial[DIVR_W-1:0];
        qbit = 1'b0;
      end
      dq_c[i] = {pdq[PROD_W-2:0], qbit};
      if (i < STAGES - 1) begin
        rem_c[i] = nrem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        v[i] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < STAGES; i++) begin
        dq[i] <= dq_c[i];
      end
      for (int i = 0; i < STAGES - 1; i++) begin
        rem[i] <= rem_c[i];
      end
      dv[0]   <= in_divisor;
      ctrl[0] <= in_ctrl;
      for (int i = 1; i < STAGES - 1; i++) begin
        dv[i] <= dv[i-1];
      end
      for (int i = 1; i < STAGES; i++) begin
        ctrl[i] <= ctrl[i-1];
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_quot  = dq[STAGES-1];
  assign out_ctrl  = ctrl[STAGES-1];

endmodule

[rtl/clkf_back.sv]
module clkf_back import clkf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  output logic              adv,
  input  logic              in_valid,
  input  logic [PROD_W-1:0] in_quot,
  input  ctrl_t             in_ctrl,
  clkf_out_if.source        result
);

  logic              va;
  logic [PROD_W-1:0] core_a;
  ctrl_t             ctrl_a;
  res_t              res_next;

  res_t              entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;

  assign adv  = (cnt != 2'd2);
  assign push = adv && va;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      core_a <= in_quot >> ahb_shift(in_ctrl.ahb);
      ctrl_a <= in_ctrl;
    end
  end

  always_comb begin
    res_next.core = sat32(core_a);
    res_next.apb1 = sat32(apb_shift(core_a, ctrl_a.apb1, 1'b0));
    res_next.apb2 = sat32(apb_shift(core_a, ctrl_a.apb2, 1'b0));
    res_next.tim1 = sat32(apb_shift(core_a, ctrl_a.apb1, 1'b1));
    res_next.tim2 = sat32(apb_shift(core_a, ctrl_a.apb2, 1'b1));
    res_next.err  = ctrl_a.err;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign result.valid         = (cnt != 2'd0);
  assign result.core_hz       = entry[rd_ptr].core;
  assign result.apb1_hz       = entry[rd_ptr].apb1;
  assign result.apb2_hz       = entry[rd_ptr].apb2;
  assign result.apb1_timer_hz = entry[rd_ptr].tim1;
  assign result.apb2_timer_hz = entry[rd_ptr].tim2;
  assign result.div_error     = entry[rd_ptr].err;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.div_error |-> result.core_hz == '0)
    else $error("div_error with nonzero core clock");

  a_apb1_order: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.apb1_timer_hz <= result.apb1_hz &&
                     result.apb1_hz <= result.core_hz)
    else $error("APB1 clocks exceed parent clock");

  a_apb2_order: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.apb2_timer_hz <= result.apb2_hz &&
                     result.apb2_hz <= result.core_hz)
    else $error("APB2 clocks exceed parent clock");

  a_count: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) && !pop |=> cnt == 2'd2)
    else $error("output queue lost an entry");

endmodule

[rtl/clock_tree_frequency_calc_top.sv]
// Clock-tree frequency calculator. Each query transaction carries the clock-control
// fields and yields one result with the core, APB1, APB2 and the two timer clock
// frequencies in hertz, saturated to 32 bits, plus div_error for a PLL with M of zero.
// One query is taken every cycle while the output queue has room; each query goes
// through the source select and the 26x9 PLL multiplier stages, then the 35-stage
// restoring divider (one quotient bit per stage). A two-entry output queue keeps
// the pipeline moving while a result waits to be taken. The oscillator registers
// (index 0 HSI, index 1 HSE) are always ready and should be written only while no
// query is in flight; other indexes are ignored.
module clock_tree_frequency_calc_top import clkf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  clkf_cfg_if.sink    cfg,
  clkf_in_if.sink     query,
  clkf_out_if.source  result
);

  logic              adv;
  logic              f_valid;
  logic [PROD_W-1:0] f_prod;
  logic [DIVR_W-1:0] f_divisor;
  ctrl_t             f_ctrl;
  logic              d_valid;
  logic [PROD_W-1:0] d_quot;
  ctrl_t             d_ctrl;

  clkf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .query       (query),
    .out_valid   (f_valid),
    .out_prod    (f_prod),
    .out_divisor (f_divisor),
    .out_ctrl    (f_ctrl)
  );

  clkf_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (f_valid),
    .in_prod    (f_prod),
    .in_divisor (f_divisor),
    .in_ctrl    (f_ctrl),
    .out_valid  (d_valid),
    .out_quot   (d_quot),
    .out_ctrl   (d_ctrl)
  );

  clkf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d_valid),
    .in_quot  (d_quot),
    .in_ctrl  (d_ctrl),
    .result   (result)
  );

endmodule

[bench/clock_tree_frequency_calc_checker.sv]
module clock_tree_frequency_calc_checker import clkf_pkg::*; (
  input  logic clk,
  input  logic rst,
  clkf_cfg_if  cfg,
  clkf_in_if   query,
  clkf_out_if  result,
  output int   fail_count,
  output int   pending
);

  logic [FREQ_W-1:0] hsi_hz;
  logic [FREQ_W-1:0] hse_hz;
  res_t              expected_clocks[$];

  function automatic logic [OUT_W-1:0] clamp_hz(input logic [63:0] v);
    if (v > 64'hFFFF_FFFF) begin
      return {OUT_W{1'b1}};
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [63:0] bus_hz(input logic [63:0] core, input logic [2:0] code,
                                         input bit timer);
    int sh;
    if (code < 3'd4) begin
      return core;
    end
    sh = int'(code) - (timer ? 2 : 3);
    return core >> sh;
  endfunction

  function automatic res_t predict_clocks(input logic [1:0] src, input logic [3:0] ahb,
                                          input logic [2:0] apb1, input logic [2:0] apb2,
                                          input logic from_hse, input logic [N_W-1:0] n,
                                          input logic [M_W-1:0] m, input logic [1:0] p);
    logic [63:0] hz;
    int          sh;
    res_t        r;
    hz    = '0;
    r.err = 1'b0;
    case (src_t'(src))
      SRC_HSI: hz = 64'(hsi_hz);
      SRC_HSE: hz = 64'(hse_hz);
      SRC_PLL: begin
        hz = 64'(from_hse ? hse_hz : hsi_hz) * 64'(n);
        if (m == '0) begin
          r.err = 1'b1;
          hz    = '0;
        end else begin
          hz = hz / 64'(m);
          hz = hz / (64'(p) * 2 + 2);
        end
      end
      default: hz = '0;
    endcase
    case (ahb)
      4'd8:    sh = 1;
      4'd9:    sh = 2;
      4'd10:   sh = 3;
      4'd11:   sh = 4;
      4'd12:   sh = 6;
      4'd13:   sh = 7;
      4'd14:   sh = 8;
      4'd15:   sh = 9;
      default: sh = 0;
    endcase
    hz     = hz >> sh;
    r.core = clamp_hz(hz);
    r.apb1 = clamp_hz(bus_hz(hz, apb1, 1'b0));
    r.apb2 = clamp_hz(bus_hz(hz, apb2, 1'b0));
    r.tim1 = clamp_hz(bus_hz(hz, apb1, 1'b1));
    r.tim2 = clamp_hz(bus_hz(hz, apb2, 1'b1));
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
    $display("%0t: clock result mismatch on %s: expected %0d, got %0d",
             $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (rst) begin
      hsi_hz     = HSI_RESET;
      hse_hz     = HSE_RESET;
      fail_count = 0;
      expected_clocks.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HSI: hsi_hz = cfg.data;
          REG_HSE: hse_hz = cfg.data;
          default: ;
        endcase
      end
      if (query.valid && query.ready) begin
        expected_clocks.push_back(predict_clocks(query.clock_source, query.ahb_prescale,
                                                 query.apb1_prescale, query.apb2_prescale,
                                                 query.pll_from_hse, query.pll_mul_n,
                                                 query.pll_div_m, query.pll_div_p_code));
      end
      if (result.valid && result.ready) begin
        if (expected_clocks.size() == 0) begin
          report_mismatch("result with no query outstanding", '0, result.core_hz);
        end else begin
          want = expected_clocks.pop_front();
          if (result.core_hz !== want.core) begin
            report_mismatch("core_hz", want.core, result.core_hz);
          end
          if (result.apb1_hz !== want.apb1) begin
            report_mismatch("apb1_hz", want.apb1, result.apb1_hz);
          end
          if (result.apb2_hz !== want.apb2) begin
            report_mismatch("apb2_hz", want.apb2, result.apb2_hz);
          end
          if (result.apb1_timer_hz !== want.tim1) begin
            report_mismatch("apb1_timer_hz", want.tim1, result.apb1_timer_hz);
          end
          if (result.apb2_timer_hz !== want.tim2) begin
            report_mismatch("apb2_timer_hz", want.tim2, result.apb2_timer_hz);
          end
          if (result.div_error !== want.err) begin
            report_mismatch("div_error", OUT_W'(want.err), OUT_W'(result.div_error));
          end
        end
      end
    end
    pending = expected_clocks.size();
  end

endmodule

[bench/clock_tree_frequency_calc_top_test.sv]
module clock_tree_frequency_calc_top_test;
  import clkf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_gaps;
  bit   always_ready;
  bit   hold_req;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  clkf_cfg_if cfg_bus();
  clkf_in_if  query_bus();
  clkf_out_if result_bus();

  clock_tree_frequency_calc_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .query  (query_bus),
    .result (result_bus)
  );

  clock_tree_frequency_calc_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_bus),
    .query      (query_bus),
    .result     (result_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_query(input src_t src, input logic [3:0] ahb, input logic [2:0] apb1,
                            input logic [2:0] apb2, input logic from_hse,
                            input logic [N_W-1:0] n, input logic [M_W-1:0] m,
                            input logic [1:0] p);
    query_bus.valid          = 1'b1;
    query_bus.clock_source   = src;
    query_bus.ahb_prescale   = ahb;
    query_bus.apb1_prescale  = apb1;
    query_bus.apb2_prescale  = apb2;
    query_bus.pll_from_hse   = from_hse;
    query_bus.pll_mul_n      = n;
    query_bus.pll_div_m      = m;
    query_bus.pll_div_p_code = p;
    do @(posedge clk); while (!query_bus.ready);
    @(negedge clk);
    query_bus.valid = 1'b0;
    repeat (pick_gap(no_gaps)) @(negedge clk);
  endtask

  task automatic send_random_query();
    src_t src;
    int   pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      src = SRC_PLL;
    end else if (pick < 7) begin
      src = SRC_HSI;
    end else if (pick < 9) begin
      src = SRC_HSE;
    end else begin
      src = SRC_NONE;
    end
    send_query(src, 4'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
               ($urandom_range(0, 7) == 0) ? '0 : N_W'($urandom),
               ($urandom_range(0, 11) == 0) ? '0 : M_W'($urandom), 2'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int gap;
    bit held;
    held             = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        result_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      result_bus.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      gap = pick_gap(always_ready);
      if (gap > 0) begin
        result_bus.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((query_bus.valid && query_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int phase;
    query_bus.valid          = 1'b0;
    query_bus.clock_source   = '0;
    query_bus.ahb_prescale   = '0;
    query_bus.apb1_prescale  = '0;
    query_bus.apb2_prescale  = '0;
    query_bus.pll_from_hse   = 1'b0;
    query_bus.pll_mul_n      = '0;
    query_bus.pll_div_m      = '0;
    query_bus.pll_div_p_code = '0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = '0;
    cfg_bus.data             = '0;
    no_gaps                  = 1'b0;
    always_ready             = 1'b0;
    hold_req                 = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_query(SRC_HSI, 4'd0, 3'd0, 3'd0, 1'b0, 9'd0, 6'd0, 2'd0);
    send_query(SRC_HSE, 4'd7, 3'd3, 3'd3, 1'b1, 9'd1, 6'd1, 2'd0);
    send_query(SRC_NONE, 4'd15, 3'd7, 3'd7, 1'b1, 9'd511, 6'd63, 2'd3);
    send_query(SRC_PLL, 4'd0, 3'd4, 3'd5, 1'b0, 9'd300, 6'd0, 2'd1);
    send_query(SRC_PLL, 4'd0, 3'd6, 3'd7, 1'b1, 9'd0, 6'd5, 2'd2);
    send_query(SRC_PLL, 4'd0, 3'd0, 3'd0, 1'b0, 9'd511, 6'd1, 2'd0);
    for (k = 8; k < 16; k++) begin
      send_query(SRC_HSI, 4'(k), 3'(4 + k % 4), 3'(7 - k % 4), 1'b0, 9'd0, 6'd0, 2'd0);
    end
    for (k = 0; k < 4; k++) begin
      send_query(SRC_PLL, 4'd0, 3'd1, 3'd2, 1'(k), 9'd336, 6'd8, 2'(k));
    end

    // saturate the PLL path with both oscillators at full scale
    drain();
    write_reg(REG_HSI, '1);
    write_reg(REG_HSE, '1);
    send_query(SRC_PLL, 4'd0, 3'd4, 3'd5, 1'b1, 9'd511, 6'd1, 2'd0);
    send_query(SRC_HSE, 4'd8, 3'd7, 3'd7, 1'b0, 9'd511, 6'd63, 2'd3);
    send_query(SRC_NONE, 4'd0, 3'd0, 3'd0, 1'b0, 9'd100, 6'd0, 2'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_HSI, '0);
          write_reg(REG_HSE, '1);
        end
        1: begin
          write_reg(REG_HSI, 26'd50000000);
          write_reg(REG_HSE, 26'd1);
          write_reg(REG_SPARE_A, FREQ_W'($urandom));
        end
        2: begin
          write_reg(REG_HSI, FREQ_W'($urandom_range(0, 50000000)));
          write_reg(REG_HSE, FREQ_W'($urandom_range(0, 50000000)));
        end
        3: begin
          write_reg(REG_HSI, FREQ_W'($urandom));
          write_reg(REG_HSE, FREQ_W'($urandom));
        end
        default: begin
          write_reg(REG_HSI, FREQ_W'($urandom_range(0, 50000000)));
          write_reg(REG_HSE, '0);
          write_reg(REG_SPARE_B, FREQ_W'($urandom));
        end
      endcase
      no_gaps      = (phase == 1) || (phase == 2);
      always_ready = (phase == 3);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // stall the output so the pipeline backs up into the input
        if (phase == 2 && k == 0) begin
          hold_req = 1'b1;
        end
        if (phase == 4 && k == PHASE_ITEMS / 2) begin
          drain();
        end
        send_random_query();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/clkf_pkg.sv
rtl/clkf_if.sv
rtl/clkf_front.sv
rtl/clkf_div.sv
rtl/clkf_back.sv
rtl/clock_tree_frequency_calc_top.sv
bench/clock_tree_frequency_calc_checker.sv
bench/clock_tree_frequency_calc_top_test.sv
